FILE: rtl/fir_equalizer_filter_unit_assert.svh
// Assertion macros for the FIR equaliser filter unit.
// Needs only a clock and a synchronous active-high reset in the including module.
`ifndef FIR_EQUALIZER_FILTER_UNIT_ASSERT_SVH
`define FIR_EQUALIZER_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FIREQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FIREQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fireq_pkg.sv
// Shared types and constants for the FIR equaliser filter unit.
// No dependencies.
`default_nettype none

package fireq_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned CIDX_W   = 7;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;

  // Q13.29 sum (at 127 taps) to Q1.15: add half an LSB, shift down
  localparam int unsigned     ROUND_SHIFT = 14;
  localparam logic signed [15:0] ROUND_BIAS = 16'sd8192;
  localparam logic signed [15:0] SAT_MAX    = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN    = -16'sh8000;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/fir_equalizer_filter_unit.sv
// Top level of the FIR equaliser filter unit: sequencer, shared MAC, rounding.
// Depends on fireq_pkg, fireq_ram and fir_equalizer_filter_unit_assert.svh.
//
//   channel | signals                                              | dir
//   --------+------------------------------------------------------+-----
//   input   | in_valid/in_ready, command, sample_in, coef_index,   | in
//           | coef_value, block_end                                |
//   output  | out_valid/out_ready, sample_out, block_end_out       | out
//   config  | cfg_wr_en, cfg_wr_data (filter enable)               | in
//
// A filtered sample walks every tap on one shared 18x16 multiplier and accumulator
// through a read/multiply/add pipeline (MAC, then drain state); no new input is
// taken until the result state has loaded the output register. A passed-through
// sample goes straight to the result state. Reset clears both stores at once
// through per-entry valid bits. A result waiting in the output register does not
// block the next input; a stalled output holds the result state.
`default_nettype none
`include "fir_equalizer_filter_unit_assert.svh"

module fir_equalizer_filter_unit #(
  parameter int unsigned NUM_TAPS = 127
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [15:0] sample_in,
  input  wire logic [6:0]  coef_index,
  input  wire logic [17:0] coef_value,
  input  wire logic        block_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      sample_out,
  output logic             block_end_out
);

  localparam int unsigned IDX_W = $clog2(NUM_TAPS);
  localparam int unsigned ACC_W = fireq_pkg::PROD_W + IDX_W + 1;
  localparam int unsigned CMP_W = (IDX_W > fireq_pkg::CIDX_W) ? IDX_W + 1
                                                               : fireq_pkg::CIDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TAPS - 1);

  fireq_pkg::state_t state, state_next;

  logic             filter_enable;
  logic [IDX_W-1:0] wr_pos;
  logic [IDX_W-1:0] tap_idx;
  logic [IDX_W-1:0] hist_pos;
  logic [NUM_TAPS-1:0] tap_vld;
  logic [NUM_TAPS-1:0] hist_vld;
  logic             rd_vld;
  logic             prod_vld;
  logic             tap_ok;
  logic             hist_ok;
  logic             pass;
  logic             blk;
  logic [15:0]      smp;
  logic [fireq_pkg::COEF_W-1:0]   tap_rd;
  logic [fireq_pkg::SAMPLE_W-1:0] hist_rd;
  logic signed [fireq_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shifted;
  logic [15:0]      sat_val;

  logic accept, push, coef_wr, coef_in_range, issue, slot_free, load_out;

  assign accept        = in_valid && in_ready;
  assign push          = accept && (command == fireq_pkg::CMD_PUSH);
  assign coef_in_range = CMP_W'(coef_index) < CMP_W'(NUM_TAPS);
  assign coef_wr       = accept && (command == fireq_pkg::CMD_COEF) && coef_in_range;
  assign slot_free     = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fireq_pkg::ST_IDLE: begin
        if (push) begin
          state_next = filter_enable ? fireq_pkg::ST_MAC : fireq_pkg::ST_RESULT;
        end
      end
      fireq_pkg::ST_MAC: begin
        if (tap_idx == LAST_IDX) begin
          state_next = fireq_pkg::ST_DRAIN;
        end
      end
      fireq_pkg::ST_DRAIN: begin
        if (!rd_vld && !prod_vld) begin
          state_next = fireq_pkg::ST_RESULT;
        end
      end
      fireq_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_next = fireq_pkg::ST_IDLE;
        end
      end
      default: state_next = fireq_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs; hold off input transfers during reset
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      fireq_pkg::ST_IDLE:   in_ready = !rst;
      fireq_pkg::ST_MAC:    issue    = 1'b1;
      fireq_pkg::ST_DRAIN:  ;
      fireq_pkg::ST_RESULT: load_out = slot_free;
      default:              ;
    endcase
  end

  // State, enable register, valid bits and write position
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fireq_pkg::ST_IDLE;
      filter_enable <= 1'b0;
      wr_pos        <= '0;
      tap_vld       <= '0;
      hist_vld      <= '0;
      rd_vld        <= 1'b0;
      prod_vld      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      prod_vld <= rd_vld;
      if (cfg_wr_en) begin
        filter_enable <= cfg_wr_data;
      end
      if (coef_wr) begin
        tap_vld[IDX_W'(coef_index)] <= 1'b1;
      end
      // Store the sample and advance the write position on a filtered push
      if (push && filter_enable) begin
        hist_vld[wr_pos] <= 1'b1;
        wr_pos           <= (wr_pos == LAST_IDX) ? '0 : wr_pos + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the item and walk the tap and history addresses
  always_ff @(posedge clk) begin
    if (push) begin
      pass     <= !filter_enable;
      blk      <= block_end;
      smp      <= sample_in;
      tap_idx  <= '0;
      hist_pos <= wr_pos;
    end else if (issue) begin
      tap_idx  <= tap_idx + 1'b1;
      hist_pos <= (hist_pos == '0) ? LAST_IDX : hist_pos - 1'b1;
    end
    tap_ok  <= tap_vld[tap_idx];
    hist_ok <= hist_vld[hist_pos];
  end

  fireq_ram #(
    .WIDTH(fireq_pkg::COEF_W),
    .DEPTH(NUM_TAPS)
  ) u_tap_ram (
    .clk    (clk),
    .wr_en  (coef_wr),
    .wr_addr(IDX_W'(coef_index)),
    .wr_data(coef_value),
    .rd_addr(tap_idx),
    .rd_data(tap_rd)
  );

  fireq_ram #(
    .WIDTH(fireq_pkg::SAMPLE_W),
    .DEPTH(NUM_TAPS)
  ) u_hist_ram (
    .clk    (clk),
    .wr_en  (push && filter_enable),
    .wr_addr(wr_pos),
    .wr_data(sample_in),
    .rd_addr(hist_pos),
    .rd_data(hist_rd)
  );

  // Multiply, then accumulate; unwritten entries read as zero
  always_ff @(posedge clk) begin
    prod <= signed'(tap_ok ? tap_rd : '0) * signed'(hist_ok ? hist_rd : '0);
    if (push) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up and saturate to Q1.15
  always_comb begin
    rnd     = acc + ACC_W'(fireq_pkg::ROUND_BIAS);
    shifted = rnd >>> fireq_pkg::ROUND_SHIFT;
    if (shifted > ACC_W'(fireq_pkg::SAT_MAX)) begin
      sat_val = fireq_pkg::SAT_MAX;
    end else if (shifted < ACC_W'(fireq_pkg::SAT_MIN)) begin
      sat_val = fireq_pkg::SAT_MIN;
    end else begin
      sat_val = shifted[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out    <= pass ? smp : sat_val;
      block_end_out <= blk;
    end
  end

  `FIREQ_ASSERT_NOW(a_tap_idx_range, clk, rst, state == fireq_pkg::ST_MAC,
    tap_idx <= LAST_IDX, "tap index beyond last tap")
  `FIREQ_ASSERT_NOW(a_wr_pos_range, clk, rst, 1'b1,
    wr_pos <= LAST_IDX, "write position out of range")
  `FIREQ_ASSERT_NOW(a_pipe_empty, clk, rst, state == fireq_pkg::ST_RESULT,
    !rd_vld && !prod_vld, "MAC pipeline busy at result")
  `FIREQ_ASSERT_NEXT(a_result_load, clk, rst, load_out,
    out_valid && state == fireq_pkg::ST_IDLE, "result not loaded")
  `FIREQ_ASSERT_NEXT(a_pos_advance, clk, rst, push && filter_enable,
    wr_pos != $past(wr_pos), "write position did not advance")

endmodule

`default_nettype wire

FILE: rtl/fireq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fireq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 127
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
